// ----- rtl/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit stack allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int MAX_SEGMENTS    = 64;
	localparam int ALIGN_BYTES     = 8;
	localparam int HEADER_BYTES    = 8;
	localparam int SPLIT_SPARE     = 64;
	localparam int POOL_SIZE_MAX   = 16777216;
	localparam int RESET_POOL_SIZE = 65536;

	localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
	localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int START_W   = 24;
	localparam int LEN_W     = 25;
	localparam int BYTES_W   = 24;
	localparam int ADDR_W    = 32;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// register indexes
	localparam logic [1:0] REG_POOL_BASE = 2'd0;
	localparam logic [1:0] REG_POOL_SIZE = 2'd1;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} seg_t;

	typedef struct packed {
		logic init_wr;
		logic cfg_wr;
		logic load;
		logic calc_off;
		logic check;
		logic scan;
		logic decide;
		logic shift;
		logic fin;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic pre_err;
		logic scan_done;
		logic dec_err;
		logic dec_remove;
		logic dec_insert;
		logic shift_done;
		logic out_full;
	} dp_stat_t;

endpackage

// ----- rtl/ffsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer: steps one operation through offset, check, scan, update,
// table shift and result hand-off.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output ffsa_pkg::dp_cmd_t cmd,
	input  ffsa_pkg::dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_OFFS, S_CHECK, S_SCAN, S_DECIDE, S_SHIFT, S_FIN, S_RESULT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT:   state_q <= S_IDLE;
				S_IDLE:   if (in_valid && !cfg_valid) state_q <= S_OFFS;
				S_OFFS:   state_q <= S_CHECK;
				S_CHECK:  state_q <= stat.pre_err ? S_RESULT : S_SCAN;
				S_SCAN:   if (stat.scan_done) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (stat.dec_err)
						state_q <= S_RESULT;
					else if (stat.dec_remove || stat.dec_insert)
						state_q <= S_SHIFT;
					else
						state_q <= S_RESULT;
				end
				S_SHIFT:  if (stat.shift_done) state_q <= S_FIN;
				S_FIN:    state_q <= S_RESULT;
				S_RESULT: if (!stat.out_full) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.init_wr  = (state_q == S_INIT);
		cmd.cfg_wr   = (state_q == S_IDLE) && cfg_valid;
		cmd.load     = (state_q == S_IDLE) && in_valid && !cfg_valid;
		cmd.calc_off = (state_q == S_OFFS);
		cmd.check    = (state_q == S_CHECK);
		cmd.scan     = (state_q == S_SCAN);
		cmd.decide   = (state_q == S_DECIDE);
		cmd.shift    = (state_q == S_SHIFT);
		cmd.fin      = (state_q == S_FIN);
		cmd.emit     = (state_q == S_RESULT) && !stat.out_full;
	end

	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);

endmodule

// ----- rtl/ffsa_dpath.sv -----
// ----------------------------------------------------------------------------
// ffsa_dpath
// Segment table memory, scan and shift engine, free-byte count, config
// registers and the result register.
// ----------------------------------------------------------------------------
module ffsa_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ffsa_pkg::dp_cmd_t               cmd,
	output ffsa_pkg::dp_stat_t              stat,
	input  logic                            in_opcode,
	input  logic [ffsa_pkg::BYTES_W-1:0]    in_byte_count,
	input  logic [ffsa_pkg::ADDR_W-1:0]     in_stack_top,
	input  logic [1:0]                      cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [1:0]                      out_status,
	output logic [ffsa_pkg::ADDR_W-1:0]     out_address,
	output logic [ffsa_pkg::LEN_W-1:0]      out_free_bytes
);

	localparam int IW = ffsa_pkg::SEG_IDX_W;
	localparam int CW = ffsa_pkg::SEG_CNT_W;
	localparam int LW = ffsa_pkg::LEN_W;
	localparam int SW = ffsa_pkg::START_W;
	localparam int AW = ffsa_pkg::ADDR_W;

	// segment table
	ffsa_pkg::seg_t mem [ffsa_pkg::MAX_SEGMENTS];
	ffsa_pkg::seg_t rdata_q;
	logic [IW-1:0]  raddr;
	logic           we;
	logic [IW-1:0]  waddr;
	ffsa_pkg::seg_t wdata;

	// config and running state
	logic [AW-1:0] base_q;
	logic [LW-1:0] size_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] total_q;

	// operation
	logic          op_q;
	logic          bzero_q;
	logic [AW-1:0] top_q;
	logic [LW-1:0] need_q;
	logic [AW-1:0] off_q;
	logic [1:0]    res_status_q;
	logic [AW-1:0] res_addr_q;

	// scan
	logic [CW-1:0]  ridx_q, cidx_q, fidx_q;
	logic           rv_q, primed_q, has_cur_q, has_prev_q;
	ffsa_pkg::seg_t cur_q, prev_q;
	logic [LW-1:0]  prev_end_q;

	// shift
	logic [CW-1:0] src_q, rem_q;
	logic          down_q, wv_q, ins_q, rm_q;
	logic [IW-1:0] wdst_q;

	// output
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [AW-1:0] out_addr_q;
	logic [LW-1:0] out_free_q;

	// block size rounding
	logic [LW:0] need_sum, need_rnd;
	assign need_sum = (LW+1)'(in_byte_count)
		+ (LW+1)'(ffsa_pkg::HEADER_BYTES + ffsa_pkg::ALIGN_BYTES - 1);
	assign need_rnd = (LW+1)'((need_sum / (LW+1)'(ffsa_pkg::ALIGN_BYTES))
		* (LW+1)'(ffsa_pkg::ALIGN_BYTES));

	// config saturation
	logic [LW-1:0] cfg_size;
	assign cfg_size = (cfg_data[LW-1:0] > LW'(ffsa_pkg::POOL_SIZE_MAX))
		? LW'(ffsa_pkg::POOL_SIZE_MAX) : cfg_data[LW-1:0];

	// pre-check
	logic [AW:0] off_end;
	assign off_end = (AW+1)'(off_q) + (AW+1)'(need_q);
	assign stat.pre_err = bzero_q || ((op_q == ffsa_pkg::OP_FREE) &&
		((top_q == '0) || (off_end > (AW+1)'(size_q))));

	// scan compare
	logic hit;
	assign hit = (op_q == ffsa_pkg::OP_FREE) ? (AW'(rdata_q.start) >= off_q)
		: (rdata_q.len >= need_q);
	assign stat.scan_done = primed_q && (!rv_q || hit);

	// decision
	logic [LW:0]   split_lim, blk_end;
	logic          split, ovl, mp, mn, full;
	logic [LW-1:0] taken;
	logic          dec_err_c, dec_remove_c, dec_insert_c;
	assign split_lim = (LW+1)'(need_q)
		+ (LW+1)'(ffsa_pkg::HEADER_BYTES + ffsa_pkg::SPLIT_SPARE);
	assign split     = (LW+1)'(cur_q.len) >= split_lim;
	assign taken     = split ? need_q : cur_q.len;
	assign blk_end   = (LW+1)'(off_q[LW-1:0]) + (LW+1)'(need_q);
	assign ovl = (has_prev_q && (prev_end_q > off_q[LW-1:0]))
		|| (has_cur_q && (blk_end > (LW+1)'(cur_q.start)));
	assign mp  = has_prev_q && (prev_end_q == off_q[LW-1:0]);
	assign mn  = has_cur_q && (blk_end == (LW+1)'(cur_q.start));
	assign full = !mp && !mn && (cnt_q >= CW'(ffsa_pkg::MAX_SEGMENTS));

	always_comb begin
		if (op_q == ffsa_pkg::OP_ALLOC) begin
			dec_err_c    = !has_cur_q;
			dec_remove_c = has_cur_q && !split;
			dec_insert_c = 1'b0;
		end else begin
			dec_err_c    = ovl || full;
			dec_remove_c = !ovl && mp && mn;
			dec_insert_c = !ovl && !mp && !mn && !full;
		end
	end

	assign stat.dec_err    = dec_err_c;
	assign stat.dec_remove = dec_remove_c;
	assign stat.dec_insert = dec_insert_c;

	assign stat.shift_done = (rem_q == '0) && !wv_q;
	assign stat.out_full   = out_valid_q;

	// memory ports
	assign raddr = cmd.scan ? ridx_q[IW-1:0] : src_q[IW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		if (cmd.init_wr) begin
			we         = 1'b1;
			wdata.len  = size_q;
		end else if (cmd.cfg_wr && (cfg_index == ffsa_pkg::REG_POOL_SIZE)) begin
			we         = 1'b1;
			wdata.len  = cfg_size;
		end else if (wv_q) begin
			we    = 1'b1;
			waddr = wdst_q;
			wdata = rdata_q;
		end else if (cmd.fin && ins_q) begin
			we          = 1'b1;
			waddr       = fidx_q[IW-1:0];
			wdata.start = off_q[SW-1:0];
			wdata.len   = need_q;
		end else if (cmd.decide && !dec_err_c) begin
			if (op_q == ffsa_pkg::OP_ALLOC) begin
				we          = split;
				waddr       = fidx_q[IW-1:0];
				wdata.start = cur_q.start + SW'(need_q);
				wdata.len   = cur_q.len - need_q;
			end else if (mp) begin
				we          = 1'b1;
				waddr       = IW'(fidx_q - CW'(1));
				wdata.start = prev_q.start;
				wdata.len   = mn ? (prev_q.len + need_q + cur_q.len) : (prev_q.len + need_q);
			end else if (mn) begin
				we          = 1'b1;
				waddr       = fidx_q[IW-1:0];
				wdata.start = off_q[SW-1:0];
				wdata.len   = cur_q.len + need_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			size_q      <= LW'(ffsa_pkg::RESET_POOL_SIZE);
			cnt_q       <= CW'(1);
			total_q     <= LW'(ffsa_pkg::RESET_POOL_SIZE);
			rv_q        <= 1'b0;
			primed_q    <= 1'b0;
			has_prev_q  <= 1'b0;
			rem_q       <= '0;
			wv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				case (cfg_index)
					ffsa_pkg::REG_POOL_BASE: base_q <= cfg_data;
					ffsa_pkg::REG_POOL_SIZE: begin
						size_q  <= cfg_size;
						total_q <= cfg_size;
						cnt_q   <= (cfg_size != '0) ? CW'(1) : '0;
					end
					default: ;
				endcase
			end

			if (cmd.check) begin
				rv_q       <= 1'b0;
				primed_q   <= 1'b0;
				has_prev_q <= 1'b0;
			end else if (cmd.scan) begin
				rv_q     <= (ridx_q < cnt_q);
				primed_q <= 1'b1;
				if (primed_q && rv_q && !hit && (op_q == ffsa_pkg::OP_FREE))
					has_prev_q <= 1'b1;
			end

			if (cmd.decide && !dec_err_c) begin
				if (op_q == ffsa_pkg::OP_ALLOC)
					total_q <= total_q - taken;
				else
					total_q <= total_q + need_q;
				if (dec_remove_c)
					rem_q <= cnt_q - CW'(1) - fidx_q;
				else if (dec_insert_c)
					rem_q <= cnt_q - fidx_q;
			end else if (cmd.shift && (rem_q != '0)) begin
				rem_q <= rem_q - CW'(1);
			end
			wv_q <= cmd.shift && (rem_q != '0);

			if (cmd.fin) begin
				if (ins_q)
					cnt_q <= cnt_q + CW'(1);
				else if (rm_q)
					cnt_q <= cnt_q - CW'(1);
			end

			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= in_opcode;
			bzero_q      <= (in_byte_count == '0);
			top_q        <= in_stack_top;
			need_q       <= need_rnd[LW-1:0];
			res_status_q <= ffsa_pkg::ST_OK;
			res_addr_q   <= '0;
		end
		if (cmd.calc_off)
			off_q <= top_q + AW'(ffsa_pkg::HEADER_BYTES) - AW'(need_q) - base_q;
		if (cmd.check) begin
			ridx_q <= '0;
			if (stat.pre_err)
				res_status_q <= ffsa_pkg::ST_ERR;
		end
		if (cmd.scan) begin
			ridx_q <= ridx_q + CW'(1);
			cidx_q <= ridx_q;
			if (primed_q && rv_q && !hit && (op_q == ffsa_pkg::OP_FREE)) begin
				prev_q     <= rdata_q;
				prev_end_q <= LW'(rdata_q.start) + rdata_q.len;
			end
			if (stat.scan_done) begin
				has_cur_q <= rv_q && hit;
				fidx_q    <= (rv_q && hit) ? cidx_q : cnt_q;
				cur_q     <= rdata_q;
			end
		end
		if (cmd.decide) begin
			ins_q  <= !dec_err_c && dec_insert_c;
			rm_q   <= !dec_err_c && dec_remove_c;
			down_q <= dec_remove_c;
			src_q  <= dec_remove_c ? (fidx_q + CW'(1)) : (cnt_q - CW'(1));
			if (dec_err_c)
				res_status_q <= full && (op_q == ffsa_pkg::OP_FREE) && !ovl
					? ffsa_pkg::ST_FULL : ffsa_pkg::ST_ERR;
			else if (op_q == ffsa_pkg::OP_ALLOC)
				res_addr_q <= base_q + AW'(cur_q.start) + AW'(taken)
					- AW'(ffsa_pkg::HEADER_BYTES);
		end
		if (cmd.shift && (rem_q != '0)) begin
			src_q  <= down_q ? (src_q + CW'(1)) : (src_q - CW'(1));
			wdst_q <= down_q ? IW'(src_q - CW'(1)) : IW'(src_q + CW'(1));
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_free_q   <= total_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_address    = out_addr_q;
	assign out_free_bytes = out_free_q;

endmodule

// ----- rtl/first_fit_stack_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_stack_allocator
// Stack pool allocator: first-fit allocate with split, address-ordered free
// with coalescing, over a table of up to 64 free segments.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata / data                       | tuser / index
//  ---------+-----------+------------------------------------+--------------
//  s_axis   | in        | [23:0] byte_count, [55:24] stack_top | opcode
//  m_axis   | out       | [31:0] address, [56:32] free_bytes   | status
//  cfg      | in        | 32-bit register value               | 0 base, 1 size
//
// One beat at a time. An item steps through offset, check, a scan of the
// table entries (first fit, or up to the insert point), and a move of
// entries when a segment is removed or inserted; scan and move go entry by
// entry, set by the single read port of the segment memory. After reset
// the block writes the first segment before it takes items. A finished
// result sits in the output register while the next item is taken; a
// stalled m_axis holds the following result back. Config writes are taken
// only while no item is in progress.
// ----------------------------------------------------------------------------
module first_fit_stack_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // [23:0] byte_count, [55:24] stack_top
	input  logic        s_axis_tuser,   // opcode: 0 allocate, 1 free
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] address, [56:32] free_bytes, rest zero
	output logic [1:0]  m_axis_tuser,   // status
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ffsa_pkg::dp_cmd_t  cmd;
	ffsa_pkg::dp_stat_t stat;

	logic [ffsa_pkg::ADDR_W-1:0] out_address;
	logic [ffsa_pkg::LEN_W-1:0]  out_free_bytes;

	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ffsa_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_opcode      (s_axis_tuser),
		.in_byte_count  (s_axis_tdata[23:0]),
		.in_stack_top   (s_axis_tdata[55:24]),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_status     (m_axis_tuser),
		.out_address    (out_address),
		.out_free_bytes (out_free_bytes)
	);

	assign m_axis_tdata = {7'd0, out_free_bytes, out_address};

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit stack allocator: a directed table of
// edge cases, then random allocate/free traffic checked against a behavioral
// model of the free-segment table, under three idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;   // [23:0] byte_count, [55:24] stack_top
	logic        s_axis_tuser;   // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [31:0] address, [56:32] free_bytes
	logic [1:0]  m_axis_tuser;   // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	first_fit_stack_allocator dut (.*);

	typedef struct {
		logic [1:0]  status;
		logic [31:0] address;
		logic [24:0] free_bytes;
	} alloc_result_t;

	typedef struct {
		logic        op;
		logic [23:0] bytes;
		logic [31:0] top;
		logic        fixed;     // result typed in below
		logic [1:0]  status;
		logic [31:0] address;
		logic [24:0] free_bytes;
	} stim_row_t;

	// model state
	logic [31:0] m_base;
	logic [24:0] m_size;
	logic [31:0] seg_start [ffsa_pkg::MAX_SEGMENTS];
	logic [31:0] seg_len   [ffsa_pkg::MAX_SEGMENTS];
	int          seg_count;
	logic [31:0] m_free;

	alloc_result_t pending_results[$];
	logic [31:0]   live_top[$];      // allocated stacks, for well-formed frees
	logic [23:0]   live_bytes[$];
	int            errors;
	int            send_idle, recv_idle;
	longint        cycle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] block_size(input logic [31:0] n);
		logic [31:0] t;
		t = n + ffsa_pkg::HEADER_BYTES;
		return ((t + ffsa_pkg::ALIGN_BYTES - 1) / ffsa_pkg::ALIGN_BYTES)
			* ffsa_pkg::ALIGN_BYTES;
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < ffsa_pkg::MAX_SEGMENTS; i++) begin
			seg_start[i] = '0;
			seg_len[i] = '0;
		end
		seg_len[0] = m_size;
		seg_count = (m_size != 0) ? 1 : 0;
		m_free = m_size;
	endfunction

	function automatic void drop_segment(input int idx);
		for (int i = idx; i + 1 < seg_count; i++) begin
			seg_start[i] = seg_start[i+1];
			seg_len[i] = seg_len[i+1];
		end
		seg_count--;
	endfunction

	function automatic logic [1:0] model_alloc(input logic [31:0] bytes,
			output logic [31:0] addr);
		logic [31:0] need, at, taken;
		addr = '0;
		if (bytes == 0) return ffsa_pkg::ST_ERR;
		need = block_size(bytes);
		for (int i = 0; i < seg_count; i++) begin
			if (seg_len[i] >= need) begin
				at = seg_start[i];
				if (seg_len[i] >= need + ffsa_pkg::HEADER_BYTES + ffsa_pkg::SPLIT_SPARE) begin
					seg_start[i] = at + need;
					seg_len[i] -= need;
					taken = need;
				end else begin
					taken = seg_len[i];
					drop_segment(i);
				end
				m_free -= taken;
				addr = m_base + at + taken - ffsa_pkg::HEADER_BYTES;
				return ffsa_pkg::ST_OK;
			end
		end
		return ffsa_pkg::ST_ERR;
	endfunction

	function automatic logic [1:0] model_release(input logic [31:0] bytes,
			input logic [31:0] top);
		logic [31:0] size, off;
		int          i;
		logic        mp, mn;
		if (bytes == 0 || top == 0) return ffsa_pkg::ST_ERR;
		size = block_size(bytes);
		off = top + ffsa_pkg::HEADER_BYTES - size - m_base;
		if ({32'd0, off} + size > {39'd0, m_size}) return ffsa_pkg::ST_ERR;
		i = 0;
		while (i < seg_count && seg_start[i] < off) i++;
		if (i > 0 && seg_start[i-1] + seg_len[i-1] > off) return ffsa_pkg::ST_ERR;
		if (i < seg_count && off + size > seg_start[i]) return ffsa_pkg::ST_ERR;
		mp = (i > 0) && (seg_start[i-1] + seg_len[i-1] == off);
		mn = (i < seg_count) && (off + size == seg_start[i]);
		if (mp && mn) begin
			seg_len[i-1] += size + seg_len[i];
			drop_segment(i);
		end else if (mp) begin
			seg_len[i-1] += size;
		end else if (mn) begin
			seg_start[i] = off;
			seg_len[i] += size;
		end else begin
			if (seg_count >= ffsa_pkg::MAX_SEGMENTS) return ffsa_pkg::ST_FULL;
			for (int j = seg_count; j > i; j--) begin
				seg_start[j] = seg_start[j-1];
				seg_len[j] = seg_len[j-1];
			end
			seg_start[i] = off;
			seg_len[i] = size;
			seg_count++;
		end
		m_free += size;
		return ffsa_pkg::ST_OK;
	endfunction

	function automatic alloc_result_t predict_result(input logic op,
			input logic [23:0] bytes, input logic [31:0] top);
		alloc_result_t r;
		logic [31:0]   a;
		a = '0;
		if (op == ffsa_pkg::OP_ALLOC) r.status = model_alloc({8'd0, bytes}, a);
		else r.status = model_release({8'd0, bytes}, top);
		r.address = (r.status == ffsa_pkg::ST_OK) ? a : '0;
		r.free_bytes = m_free[24:0];
		// remember live stacks for later well-formed frees
		if (op == ffsa_pkg::OP_ALLOC && r.status == ffsa_pkg::ST_OK) begin
			live_top.push_back(a);
			live_bytes.push_back(bytes);
		end
		return r;
	endfunction

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 3_000_000) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result checker and receiver stall
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat status=%0d addr=%h", $time,
					m_axis_tuser, m_axis_tdata[31:0]);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tuser !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[31:0] !== e.address) begin
					$display("%0t: address exp %h got %h", $time, e.address,
						m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[56:32] !== e.free_bytes) begin
					$display("%0t: free_bytes exp %0d got %0d", $time, e.free_bytes,
						m_axis_tdata[56:32]);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == ffsa_pkg::REG_POOL_BASE) begin
			m_base = val;
		end else begin
			m_size = (val[24:0] > 25'(ffsa_pkg::POOL_SIZE_MAX))
				? 25'(ffsa_pkg::POOL_SIZE_MAX) : val[24:0];
			table_reset();
			live_top.delete();
			live_bytes.delete();
		end
	endtask

	// one beat into the block; a fixed expectation overrides the model's
	task automatic send_item(input stim_row_t row);
		alloc_result_t r;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser <= row.op;
		s_axis_tdata <= {row.top, row.bytes};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = predict_result(row.op, row.bytes, row.top);
		if (row.fixed) begin
			if (r.status !== row.status || r.address !== row.address ||
					r.free_bytes !== row.free_bytes) begin
				$display("%0t: directed row exp %0d/%h/%0d model %0d/%h/%0d", $time,
					row.status, row.address, row.free_bytes, r.status, r.address,
					r.free_bytes);
				errors++;
			end
			r.status = row.status;
			r.address = row.address;
			r.free_bytes = row.free_bytes;
		end
		pending_results.push_back(r);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic stim_row_t row(input logic op, input logic [23:0] b,
			input logic [31:0] t);
		stim_row_t s;
		s = '{op, b, t, 1'b0, ffsa_pkg::ST_OK, 32'd0, 25'd0};
		return s;
	endfunction

	function automatic stim_row_t fixed_row(input logic op, input logic [23:0] b,
			input logic [31:0] t, input logic [1:0] st, input logic [31:0] a,
			input logic [24:0] f);
		stim_row_t s;
		s = '{op, b, t, 1'b1, st, a, f};
		return s;
	endfunction

	task automatic random_phase(input int count);
		stim_row_t s;
		int        k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 45) begin
				// mostly small stacks, a few huge ones
				s = row(ffsa_pkg::OP_ALLOC, ($urandom_range(9) == 0) ? 24'($urandom) :
					24'($urandom_range(1, 600)), $urandom);
			end else if (k < 85 && live_top.size() != 0) begin
				int p;
				p = $urandom_range(live_top.size() - 1);
				s = row(ffsa_pkg::OP_FREE, live_bytes[p], live_top[p]);
				live_top.delete(p);
				live_bytes.delete(p);
			end else if (k < 92 && live_top.size() != 0) begin
				// double free or shifted free
				int p;
				p = $urandom_range(live_top.size() - 1);
				s = row(ffsa_pkg::OP_FREE, live_bytes[p],
					live_top[p] + 8 * $urandom_range(0, 2));
			end else begin
				s = row(logic'($urandom_range(1)), ($urandom_range(7) == 0) ? 24'd0 :
					24'($urandom), ($urandom_range(7) == 0) ? 32'd0 : $urandom);
			end
			send_item(s);
		end
	endtask

	stim_row_t directed[$];

	initial begin
		errors = 0;
		send_idle = 32;
		recv_idle = 57;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ffsa_pkg::OP_ALLOC;
		cfg_valid = 1'b0;
		cfg_index = ffsa_pkg::REG_POOL_BASE;
		cfg_data = '0;
		m_base = '0;
		m_size = 25'(ffsa_pkg::RESET_POOL_SIZE);
		table_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset: base 0, size 65536
		directed = '{
			fixed_row(ffsa_pkg::OP_ALLOC, 24'd0, 32'd0, ffsa_pkg::ST_ERR, 32'd0,
				25'd65536),                                                   // zero size
			fixed_row(ffsa_pkg::OP_FREE, 24'd0, 32'd100, ffsa_pkg::ST_ERR, 32'd0,
				25'd65536),
			fixed_row(ffsa_pkg::OP_FREE, 24'd16, 32'd0, ffsa_pkg::ST_ERR, 32'd0,
				25'd65536),                                                   // null top
			fixed_row(ffsa_pkg::OP_ALLOC, 24'd1, 32'hFFFF_FFFF, ffsa_pkg::ST_OK, 32'd8,
				25'd65520),
			fixed_row(ffsa_pkg::OP_ALLOC, 24'hFF_FFFF, 32'd0, ffsa_pkg::ST_ERR, 32'd0,
				25'd65520),                                                   // no fit
			fixed_row(ffsa_pkg::OP_FREE, 24'd1, 32'd8, ffsa_pkg::ST_OK, 32'd0,
				25'd65536),
			fixed_row(ffsa_pkg::OP_FREE, 24'd1, 32'd8, ffsa_pkg::ST_ERR, 32'd0,
				25'd65536),                                                   // double free
			fixed_row(ffsa_pkg::OP_FREE, 24'd8, 32'hFFFF_FFF8, ffsa_pkg::ST_ERR, 32'd0,
				25'd65536),                                                   // outside
			row(ffsa_pkg::OP_ALLOC, 24'd100, 32'd0),
			row(ffsa_pkg::OP_ALLOC, 24'd200, 32'd0),
			row(ffsa_pkg::OP_ALLOC, 24'd300, 32'd0),
			row(ffsa_pkg::OP_ALLOC, 24'd65400, 32'd0),  // no fit: larger than what is left
			row(ffsa_pkg::OP_FREE, 24'd200, 32'd320),   // middle, isolated
			row(ffsa_pkg::OP_FREE, 24'd100, 32'd112),   // merges with next
			row(ffsa_pkg::OP_FREE, 24'd300, 32'd632)    // overlaps the next free segment
		};
		foreach (directed[i]) send_item(directed[i]);
		drain();

		// small pool near the top of the address space
		write_reg(ffsa_pkg::REG_POOL_BASE, 32'hFFFF_F000);
		write_reg(ffsa_pkg::REG_POOL_SIZE, 32'd2048);
		random_phase(250);
		drain();
		// pool size above the cap saturates; zero pool has no segment
		write_reg(ffsa_pkg::REG_POOL_SIZE, 32'h01FF_FFFF);
		send_item(fixed_row(ffsa_pkg::OP_ALLOC, 24'hFF_FFF0, 32'd0, ffsa_pkg::ST_OK,
			32'hFFFF_F000 + 32'hFF_FFF8, 25'd0));
		drain();
		write_reg(ffsa_pkg::REG_POOL_SIZE, 32'd0);
		send_item(fixed_row(ffsa_pkg::OP_ALLOC, 24'd1, 32'd0, ffsa_pkg::ST_ERR, 32'd0,
			25'd0));
		drain();

		// fill the table with isolated holes to reach the full case
		write_reg(ffsa_pkg::REG_POOL_BASE, 32'd0);
		write_reg(ffsa_pkg::REG_POOL_SIZE, 32'd16384);
		for (int i = 0; i < 140; i++) send_item(row(ffsa_pkg::OP_ALLOC, 24'd8, 32'd0));
		for (int i = 0; i < 140; i += 2)
			send_item(row(ffsa_pkg::OP_FREE, 24'd8, 32'd16 * i + 8));
		random_phase(150);
		drain();

		send_idle = 57;
		recv_idle = 32;
		write_reg(ffsa_pkg::REG_POOL_BASE, 32'h1234_5678);
		write_reg(ffsa_pkg::REG_POOL_SIZE, 32'd65536);
		random_phase(350);
		// hold off until everything is back, then carry on
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
		random_phase(100);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_reg(ffsa_pkg::REG_POOL_BASE, 32'hFFFF_FFFF);
		write_reg(ffsa_pkg::REG_POOL_SIZE, 32'd4096);
		random_phase(300);
		drain();

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
